>>> design/extended_gcd_modular_inverse_top_macros.svh
// Assertion helpers used by the checker file egcd_checker.sv.
`ifndef EXTENDED_GCD_MODULAR_INVERSE_TOP_MACROS_SVH
`define EXTENDED_GCD_MODULAR_INVERSE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define EGCD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define EGCD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/egcd_pkg.sv
package egcd_pkg;

  localparam int OPERAND_BITS = 32;
  localparam int COEF_BITS    = OPERAND_BITS + 1;
  localparam int MAX_STEPS    = 2 * OPERAND_BITS + 4;
  localparam int STEP_W       = $clog2(MAX_STEPS + 1);
  localparam int DIV_CNT_W    = $clog2(OPERAND_BITS + 1);

  typedef logic [OPERAND_BITS-1:0]        operand_t;
  typedef logic signed [COEF_BITS-1:0]    coef_t;
  typedef logic [STEP_W-1:0]              step_t;
  typedef logic [DIV_CNT_W-1:0]           div_cnt_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_UPDATE,
    S_DONE
  } egcd_state_t;

  // Sequencer to divide unit.
  typedef struct packed {
    logic     start;
    operand_t dividend;
    operand_t divisor;
    coef_t    x_mul;
    coef_t    y_mul;
  } egcd_div_ctrl_t;

  // Divide unit back to sequencer.
  typedef struct packed {
    logic     busy;
    operand_t remainder;
    coef_t    prod_x;
    coef_t    prod_y;
  } egcd_div_stat_t;

endpackage

>>> design/egcd_if.sv
interface egcd_operand_if import egcd_pkg::*; ();
  logic     valid;
  logic     ready;
  operand_t operand_a;
  operand_t operand_b;

  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface egcd_result_if import egcd_pkg::*; ();
  logic     valid;
  logic     ready;
  operand_t gcd_value;
  coef_t    coef_x;
  coef_t    coef_y;
  coef_t    inverse;
  logic     has_inverse;

  modport source (output valid, output gcd_value, output coef_x, output coef_y,
                  output inverse, output has_inverse, input ready);
  modport sink   (input valid, input gcd_value, input coef_x, input coef_y,
                  input inverse, input has_inverse, output ready);
endinterface

>>> design/egcd_divstep.sv
// Restoring divider, one quotient bit a cycle. Each quotient bit also
// feeds two Horner accumulators, so the unit leaves q*x_mul and q*y_mul
// (modulo the coefficient width) next to the remainder.
module egcd_divstep import egcd_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  egcd_div_ctrl_t ctrl,
  output egcd_div_stat_t stat
);

  logic                  busy;
  div_cnt_t              cnt;
  operand_t              dvd;
  operand_t              rem;
  coef_t                 acc_x;
  coef_t                 acc_y;

  logic [OPERAND_BITS:0] rem_shift;
  logic [OPERAND_BITS:0] div_ext;
  logic [OPERAND_BITS:0] rem_diff;
  logic                  qbit;
  operand_t              rem_next;
  coef_t                 acc_x_next;
  coef_t                 acc_y_next;

  always_comb begin
    rem_shift  = {rem, dvd[OPERAND_BITS-1]};
    div_ext    = {1'b0, ctrl.divisor};
    rem_diff   = rem_shift - div_ext;
    qbit       = (rem_shift >= div_ext);
    rem_next   = qbit ? rem_diff[OPERAND_BITS-1:0] : rem_shift[OPERAND_BITS-1:0];
    acc_x_next = {acc_x[COEF_BITS-2:0], 1'b0} + (qbit ? ctrl.x_mul : '0);
    acc_y_next = {acc_y[COEF_BITS-2:0], 1'b0} + (qbit ? ctrl.y_mul : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctrl.start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(OPERAND_BITS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == div_cnt_t'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      dvd   <= ctrl.dividend;
      rem   <= '0;
      acc_x <= '0;
      acc_y <= '0;
    end else if (busy) begin
      dvd   <= {dvd[OPERAND_BITS-2:0], 1'b0};
      rem   <= rem_next;
      acc_x <= acc_x_next;
      acc_y <= acc_y_next;
    end
  end

  assign stat.busy      = busy;
  assign stat.remainder = rem;
  assign stat.prod_x    = acc_x;
  assign stat.prod_y    = acc_y;

endmodule

>>> design/extended_gcd_modular_inverse_top.sv
// Extended Euclid with modular inverse. Each operand transfer (operand_a,
// operand_b) yields one result transfer: gcd_value, Bezout coefficients
// coef_x and coef_y with a*x + b*y = gcd, and inverse = coef_x when the gcd
// is one (has_inverse set), else zero. The inverse is signed and not reduced
// into [0, b). A zero modulus gives gcd = a, x = 1, y = 0. One item is in
// flight at a time: operands.ready is high only while the sequencer idles
// out of reset. Each of the k Euclid steps runs the shared bit-serial
// divider, one quotient bit a cycle, then updates the working set. For
// 32-bit operands k is at most 46 (consecutive Fibonacci numbers, plus
// one swapping step when a < b). A finished result sits in an output
// register, so the next operands are taken while it waits for
// results.ready.
module extended_gcd_modular_inverse_top import egcd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  egcd_operand_if.sink  operands,
  egcd_result_if.source results
);

  localparam step_t MAX_STEP_CNT = STEP_W'(MAX_STEPS);

  egcd_state_t    state;
  egcd_state_t    state_next;

  // Euclid working set: remainders and both coefficient pairs.
  operand_t       a;
  operand_t       b;
  coef_t          x0;
  coef_t          x1;
  coef_t          y0;
  coef_t          y1;
  step_t          step;

  // Output register.
  logic           res_valid;
  operand_t       res_gcd;
  coef_t          res_x;
  coef_t          res_y;
  coef_t          res_inv;
  logic           res_has;
  logic           res_load;

  egcd_div_ctrl_t div_ctrl;
  egcd_div_stat_t div_stat;

  logic           in_xfer;
  logic           out_xfer;
  logic           loop_end;

  egcd_divstep u_divstep (
    .clk  (clk),
    .rst  (rst),
    .ctrl (div_ctrl),
    .stat (div_stat)
  );

  assign in_xfer  = operands.valid && operands.ready;
  assign out_xfer = results.valid && results.ready;
  // Stop on a zero remainder; the step bound is never the limit for
  // in-range operands but keeps the loop finite.
  assign loop_end = (b == '0) || (step == MAX_STEP_CNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next        = state;
    operands.ready    = 1'b0;
    res_load          = 1'b0;
    div_ctrl.start    = 1'b0;
    div_ctrl.dividend = a;
    div_ctrl.divisor  = b;
    div_ctrl.x_mul    = x1;
    div_ctrl.y_mul    = y1;
    unique case (state)
      S_IDLE: begin
        // Take nothing while reset is held.
        operands.ready = !rst;
        if (operands.valid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (loop_end) begin
          state_next = S_DONE;
        end else begin
          div_ctrl.start = 1'b1;
          state_next     = S_DIV;
        end
      end
      S_DIV: begin
        // Wait out the divider; quotient products are ready when it drops busy.
        if (!div_stat.busy) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        state_next = S_CHECK;
      end
      S_DONE: begin
        // Hold here until the output register is free or being drained.
        if (!res_valid || results.ready) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Working set: load on transfer, advance one Euclid step per update.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a    <= operands.operand_a;
      b    <= operands.operand_b;
      x0   <= coef_t'(1);
      x1   <= '0;
      y0   <= '0;
      y1   <= coef_t'(1);
      step <= '0;
    end else if (state == S_UPDATE) begin
      a    <= b;
      b    <= div_stat.remainder;
      x0   <= x1;
      x1   <= x0 - div_stat.prod_x;
      y0   <= y1;
      y1   <= y0 - div_stat.prod_y;
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (out_xfer) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_gcd <= a;
      res_x   <= x0;
      res_y   <= y0;
      res_has <= (a == operand_t'(1));
      res_inv <= (a == operand_t'(1)) ? x0 : '0;
    end
  end

  assign results.valid       = res_valid;
  assign results.gcd_value   = res_gcd;
  assign results.coef_x      = res_x;
  assign results.coef_y      = res_y;
  assign results.inverse     = res_inv;
  assign results.has_inverse = res_has;

endmodule

>>> design/egcd_checker.sv
`include "extended_gcd_modular_inverse_top_macros.svh"

module egcd_checker import egcd_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     out_valid,
  input logic     out_ready,
  input operand_t gcd_value,
  input coef_t    coef_x,
  input coef_t    coef_y,
  input coef_t    inverse,
  input logic     has_inverse
);

  `EGCD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `EGCD_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(gcd_value) && $stable(coef_x) && $stable(coef_y), "stalled result changed")
  `EGCD_ASSERT_IMP(a_flag_gcd, out_valid, has_inverse == (gcd_value == operand_t'(1)), "inverse flag disagrees with gcd")
  `EGCD_ASSERT_IMP(a_inv_zero, out_valid && !has_inverse, inverse == '0, "inverse nonzero without flag")
  `EGCD_ASSERT_IMP(a_inv_coef, out_valid && has_inverse, inverse == coef_x, "inverse differs from coef_x")

endmodule

bind extended_gcd_modular_inverse_top egcd_checker u_egcd_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .gcd_value   (results.gcd_value),
  .coef_x      (results.coef_x),
  .coef_y      (results.coef_y),
  .inverse     (results.inverse),
  .has_inverse (results.has_inverse)
);
